// ===== sv/msci_pkg.sv =====
`timescale 1ns / 1ps

package msci_pkg;

  // Start codes as they appear in one aligned big-endian word.
  localparam logic [31:0] CODE_GOP   = 32'h0000_01B8;
  localparam logic [31:0] CODE_VIDEO = 32'h0000_01E0;
  localparam logic [31:0] CODE_AUDIO = 32'h0000_01C0;

  // Configuration space: one 32-bit register, word addressed by paddr[2].
  localparam int unsigned ADDR_W = 3;
  localparam logic [0:0]  REG_TIME_STEP = 1'b0;
  localparam logic [31:0] TIME_STEP_RST = 32'd500000000;

  // Queue control from the producing and consuming sides.
  typedef struct packed {
    logic push;
    logic pop;
  } msci_qctl_t;

  // Queue status back to both sides.
  typedef struct packed {
    logic empty;
    logic full;
  } msci_qstat_t;

endpackage

// ===== sv/msci_front.sv =====
`timescale 1ns / 1ps

module msci_front #(
  parameter int unsigned POS_BITS = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                space_i,
  input  logic [31:0]         stream_word_i,
  output logic                push_o,
  output logic [POS_BITS-1:0] video_mark_o,
  output logic [POS_BITS-1:0] audio_pos_o
);
  import msci_pkg::*;

  logic [POS_BITS-1:0] byte_pos_q, byte_pos_d;
  logic [POS_BITS-1:0] video_mark_q, video_mark_d;
  logic                gop_seen_q, gop_seen_d;
  logic                accept;

  assign accept = in_valid_i && space_i;

  always_comb begin
    byte_pos_d   = byte_pos_q;
    video_mark_d = video_mark_q;
    gop_seen_d   = gop_seen_q;
    push_o       = 1'b0;
    if (accept) begin
      byte_pos_d = byte_pos_q + POS_BITS'(4);
      if (stream_word_i == CODE_VIDEO && !gop_seen_q) begin
        video_mark_d = byte_pos_q;
      end
      if (stream_word_i == CODE_GOP) begin
        gop_seen_d = 1'b1;
      end
      // A record closes the group: both marks start afresh.
      if (stream_word_i == CODE_AUDIO && gop_seen_q) begin
        push_o       = 1'b1;
        video_mark_d = '0;
        gop_seen_d   = 1'b0;
      end
    end
  end

  assign video_mark_o = video_mark_q;
  assign audio_pos_o  = byte_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q   <= '0;
      video_mark_q <= '0;
      gop_seen_q   <= 1'b0;
    end else begin
      byte_pos_q   <= byte_pos_d;
      video_mark_q <= video_mark_d;
      gop_seen_q   <= gop_seen_d;
    end
  end

endmodule

// ===== sv/msci_queue.sv =====
`timescale 1ns / 1ps

module msci_queue #(
  parameter int unsigned WIDTH = 96
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  msci_pkg::msci_qctl_t    ctl_i,
  input  logic [WIDTH-1:0]        wdata_i,
  output msci_pkg::msci_qstat_t   stat_o,
  output logic [WIDTH-1:0]        rdata_o
);
  import msci_pkg::*;

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign do_push = ctl_i.push && !stat_o.full;
  assign do_pop  = ctl_i.pop && !stat_o.empty;

  assign stat_o.empty = (count_q == 2'd0);
  assign stat_o.full  = (count_q == 2'd2);
  assign rdata_o      = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

endmodule

// ===== sv/msci_back.sv =====
`timescale 1ns / 1ps

module msci_back #(
  parameter int unsigned BLOCK_BITS = 15,
  parameter int unsigned POS_BITS   = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                avail_i,
  input  logic [POS_BITS-1:0] video_mark_i,
  input  logic [POS_BITS-1:0] audio_pos_i,
  input  logic [31:0]         time_step_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [63:0]         record_time_o,
  output logic [47:0]         block_position_o,
  output logic [14:0]         video_in_block_o,
  output logic [31:0]         av_distance_o
);
  import msci_pkg::*;

  localparam logic [POS_BITS-1:0] BlockMask =
      POS_BITS'((65'(1) << BLOCK_BITS) - 65'(1));

  logic [63:0]         time_acc_q, time_acc_d;
  logic                out_valid_q, out_valid_d;
  logic [63:0]         rec_time_q;
  logic [47:0]         blk_pos_q;
  logic [14:0]         vid_off_q;
  logic [31:0]         aud_off_q;
  logic [POS_BITS-1:0] blk_full, off_full, diff_full;
  logic [63:0]         blk_wide, off_wide, diff_wide;

  assign pop_o = avail_i && (!out_valid_q || out_ready_i);

  assign blk_full  = video_mark_i & ~BlockMask;
  assign off_full  = video_mark_i & BlockMask;
  assign diff_full = audio_pos_i - video_mark_i;
  assign blk_wide  = 64'(blk_full);
  assign off_wide  = 64'(off_full);
  assign diff_wide = 64'(diff_full);

  always_comb begin
    time_acc_d  = time_acc_q;
    out_valid_d = out_valid_q;
    if (pop_o) begin
      time_acc_d  = time_acc_q + 64'(time_step_i);
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_time_q <= time_acc_q;
      blk_pos_q  <= blk_wide[47:0];
      vid_off_q  <= off_wide[14:0];
      aud_off_q  <= diff_wide[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_acc_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      time_acc_q  <= time_acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign record_time_o    = rec_time_q;
  assign block_position_o = blk_pos_q;
  assign video_in_block_o = vid_off_q;
  assign av_distance_o    = aud_off_q;

endmodule

// ===== sv/mpeg_start_code_indexer_unit.sv =====
`timescale 1ns / 1ps
// Channel   | Direction | Handshake              | Word
// ----------+-----------+------------------------+-----------------------------------------
// input     | in        | in_valid_i/in_ready_o  | stream_word_i (32 bits)
// output    | out       | out_valid_o/out_ready_i| record_time_o, block_position_o,
//           |           |                        | video_in_block_o, av_distance_o
// config    | in        | psel/penable/pready    | paddr, pwdata, prdata (time_step)
//
// One stream word is taken every cycle while the queue is not full. The record
// that an audio word closes is written into the queue at the edge that accepts
// the word, and into the output register once the back pops it from the queue;
// it is offered from that register. The two-entry queue between front and back
// absorbs output stalls: input is held off only when the queue is full. Reset is
// asynchronous and active low; it clears the positions, the group flag, the
// timestamp and the queue, and restores the time step to half a second.

module mpeg_start_code_indexer_unit #(
  parameter int unsigned BLOCK_BITS = 15,
  parameter int unsigned POS_BITS   = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [31:0]                 stream_word_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [63:0]                 record_time_o,
  output logic [47:0]                 block_position_o,
  output logic [14:0]                 video_in_block_o,
  output logic [31:0]                 av_distance_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msci_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import msci_pkg::*;

  logic [31:0]           time_step_q;
  logic                  push;
  logic                  pop;
  logic [POS_BITS-1:0]   fr_mark, fr_pos, bk_mark, bk_pos;
  msci_qctl_t            q_ctl;
  msci_qstat_t           q_stat;

  // Configuration: the only register sits at word address zero. Other word
  // addresses read as zero and ignore writes.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIME_STEP) ? time_step_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= TIME_STEP_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_TIME_STEP) begin
      time_step_q <= pwdata;
    end
  end

  // The front scans every word; only closed groups enter the queue.
  assign in_ready_o = !q_stat.full;

  msci_front #(
    .POS_BITS(POS_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .space_i      (in_ready_o),
    .stream_word_i(stream_word_i),
    .push_o       (push),
    .video_mark_o (fr_mark),
    .audio_pos_o  (fr_pos)
  );

  assign q_ctl.push = push;
  assign q_ctl.pop  = pop;

  msci_queue #(
    .WIDTH(2 * POS_BITS)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (q_ctl),
    .wdata_i({fr_mark, fr_pos}),
    .stat_o (q_stat),
    .rdata_o({bk_mark, bk_pos})
  );

  // The back formats one record per queue entry and advances the timestamp
  // by the step that is current when the record leaves the queue.
  msci_back #(
    .BLOCK_BITS(BLOCK_BITS),
    .POS_BITS  (POS_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .avail_i         (!q_stat.empty),
    .video_mark_i    (bk_mark),
    .audio_pos_i     (bk_pos),
    .time_step_i     (time_step_q),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .record_time_o   (record_time_o),
    .block_position_o(block_position_o),
    .video_in_block_o(video_in_block_o),
    .av_distance_o   (av_distance_o)
  );

endmodule

// ===== sv/msci_checker.sv =====
`timescale 1ns / 1ps

module msci_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [31:0] stream_word_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] record_time_o,
  input logic [47:0] block_position_o,
  input logic [14:0] video_in_block_o,
  input logic [31:0] av_distance_o,
  input logic        pready
);
  import msci_pkg::*;

  // A stalled record keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(record_time_o)
      && $stable(block_position_o) && $stable(video_in_block_o)
      && $stable(av_distance_o))
    else $error("stalled record changed");

  // A fresh record follows an accepted audio word, through the queue and the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2)
      && $past(stream_word_i, 2) == CODE_AUDIO)
    else $error("record without a closing audio word");

  // Input is held off only while a record waits at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with the output empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("configuration port not ready");

endmodule

bind mpeg_start_code_indexer_unit msci_checker u_msci_checker (.*);

// ===== verif/tb_mpeg_start_code_indexer_unit.sv =====
`timescale 1ns / 1ps

// Testbench for the MPEG start code indexer.
//
// Every word accepted on the input channel is fed to an in-bench predictor.
// The predictor tracks the byte position, the video mark, the GOP flag and the
// running timestamp. Whenever a word closes a record, the predictor queues the
// record that the unit should return. A checker process pops the oldest queued
// record for every word accepted on the output channel and compares it field
// by field. Directed tests go first. They cover a GOP at the very first
// position, codes that must be ignored, several time steps including both
// extremes, and a write to an unused register. The random traffic that follows
// mostly contains well-formed video/GOP/audio groups, mixed with noise and
// broken groups, under three idling regimes.
module tb_mpeg_start_code_indexer_unit;
  import msci_pkg::*;

  localparam int unsigned BLOCK_BITS    = 15;
  localparam int unsigned BLOCK_BYTES   = 1 << BLOCK_BITS;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned CODES_PER_RUN = 220;

  // Byte addresses on the configuration port; the second one maps to no register.
  localparam logic [ADDR_W-1:0] ADDR_TIME_STEP = {REG_TIME_STEP, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_NO_REG    = {~REG_TIME_STEP, 2'b00};

  typedef struct packed {
    logic [63:0] record_time;
    logic [47:0] block_position;
    logic [14:0] video_in_block;
    logic [31:0] av_distance;
  } index_record_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [31:0] stream_word_i  = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [63:0] record_time_o;
  logic [47:0] block_position_o;
  logic [14:0] video_in_block_o;
  logic [31:0] av_distance_o;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Predictor state. It mirrors what the unit should hold after every accepted word.
  logic [47:0] stream_pos  = '0;
  logic [47:0] video_pos   = '0;
  logic        gop_pending = 1'b0;
  logic [63:0] stamp_next  = '0;
  logic [31:0] step_ns     = TIME_STEP_RST;

  index_record_t pending_records[$];

  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 85;
  int unsigned codes_sent    = 0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;

  mpeg_start_code_indexer_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .stream_word_i    (stream_word_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .record_time_o    (record_time_o),
    .block_position_o (block_position_o),
    .video_in_block_o (video_in_block_o),
    .av_distance_o    (av_distance_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // A hung handshake or a record that never turns up ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The receiving side stalls at random, at the rate that the current phase asks.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Every output word is held against the oldest record that is still owed.
  always @(posedge clk_i) begin
    index_record_t owed;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_records.size() == 0) begin
        $error("record with none expected: time %0h block %0h video %0h audio %0h",
               record_time_o, block_position_o, video_in_block_o, av_distance_o);
        fail_count++;
      end else begin
        owed = pending_records.pop_front();
        if (record_time_o !== owed.record_time) begin
          $error("record_time: expected %0h, got %0h", owed.record_time, record_time_o);
          fail_count++;
        end
        if (block_position_o !== owed.block_position) begin
          $error("block_position: expected %0h, got %0h",
                 owed.block_position, block_position_o);
          fail_count++;
        end
        if (video_in_block_o !== owed.video_in_block) begin
          $error("video_in_block: expected %0h, got %0h",
                 owed.video_in_block, video_in_block_o);
          fail_count++;
        end
        if (av_distance_o !== owed.av_distance) begin
          $error("av_distance: expected %0h, got %0h", owed.av_distance, av_distance_o);
          fail_count++;
        end
      end
    end
  end

  // Advances the predictor by one stream word and queues the record that it closes.
  // A video code only moves the mark while no GOP is pending. An audio code
  // only closes a record once a GOP has been seen, and the record clears both marks.
  function automatic void predict_word(input logic [31:0] w);
    index_record_t rec;
    logic [47:0]   gap;
    if (w == CODE_VIDEO && !gop_pending) video_pos = stream_pos;
    if (w == CODE_GOP) gop_pending = 1'b1;
    if (w == CODE_AUDIO && gop_pending) begin
      gap                = stream_pos - video_pos;
      rec.record_time    = stamp_next;
      rec.block_position = video_pos & ~48'(BLOCK_BYTES - 1);
      rec.video_in_block = video_pos[BLOCK_BITS-1:0];
      rec.av_distance    = gap[31:0];
      pending_records.push_back(rec);
      stamp_next  = stamp_next + 64'(step_ns);
      video_pos   = '0;
      gop_pending = 1'b0;
    end
    stream_pos = stream_pos + 48'd4;
  endfunction

  // Any word that is none of the three start codes.
  function automatic logic [31:0] filler_word();
    logic [31:0] w;
    w = $urandom();
    if (w == CODE_GOP || w == CODE_VIDEO || w == CODE_AUDIO) w = w ^ 32'h1;
    return w;
  endfunction

  // Offers one word, with random idle cycles in front, and waits until it is taken.
  // Valid is left high on return, so that back-to-back words keep it high throughout.
  task automatic send_word(input logic [31:0] w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predict_word(w);
    if (w == CODE_GOP || w == CODE_VIDEO || w == CODE_AUDIO) codes_sent++;
  endtask

  task automatic send_fillers(input int unsigned count);
    repeat (count) send_word(filler_word());
  endtask

  // Stops sending and waits for every owed record to arrive. A word that produces
  // no record may still be in flight, so the task then also waits SETTLE_CYCLES.
  task automatic wait_for_records();
    in_valid_i <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One configuration write: a setup phase, then an access phase that holds until pready.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_TIME_STEP) step_ns = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // The very first word sits at byte 0. A GOP there must still arm the audio code.
  // With no video code yet, the record refers to position zero. Its timestamp is
  // zero, and the step from reset shows up in the timestamp of the record after it.
  task automatic test_gop_at_start();
    send_word(CODE_GOP);
    send_word(CODE_AUDIO);
  endtask

  // Covers the codes that must be ignored and the words that nearly match a code.
  // It then checks that the last video code before the GOP is the one kept.
  task automatic test_code_handling();
    send_word(CODE_AUDIO);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(CODE_GOP ^ 32'h1);
    send_word(CODE_VIDEO ^ 32'h1);
    send_word(CODE_AUDIO ^ 32'h1);
    send_word(CODE_AUDIO | 32'h8000_0000);
    send_word(CODE_VIDEO);
    send_fillers(2);
    send_word(CODE_VIDEO);
    send_word(CODE_GOP);
    send_word(CODE_VIDEO);
    send_word(CODE_GOP);
    send_word(CODE_AUDIO);
    // A video code followed by audio without a GOP leaves the mark standing.
    send_word(CODE_VIDEO);
    send_word(CODE_AUDIO);
    send_word(CODE_GOP);
    send_word(CODE_AUDIO);
  endtask

  // Steps the time step through both extremes and back. Each step is checked by a
  // pair of records. A write to the unused address must leave the step alone.
  task automatic test_time_step();
    logic [31:0] steps[4];
    steps = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd40_000_000};
    foreach (steps[i]) begin
      wait_for_records();
      write_reg(ADDR_TIME_STEP, steps[i]);
      repeat (2) begin
        send_word(CODE_VIDEO);
        send_word(CODE_GOP);
        send_word(CODE_AUDIO);
      end
    end
    wait_for_records();
    write_reg(ADDR_NO_REG, 32'h1234_5678);
    send_word(CODE_GOP);
    send_word(CODE_AUDIO);
    send_word(CODE_GOP);
    send_word(CODE_AUDIO);
  endtask

  // A video/GOP/audio group with random filler in between. Now and then the group
  // gets a stray code after the GOP, or it is broken off before its audio code.
  task automatic send_group();
    int unsigned n_video;
    n_video = $urandom_range(0, 3);
    repeat (n_video) begin
      send_fillers($urandom_range(0, 4));
      send_word(CODE_VIDEO);
    end
    send_fillers($urandom_range(0, 3));
    send_word(CODE_GOP);
    if ($urandom_range(0, 3) == 0) send_word(CODE_VIDEO);
    if ($urandom_range(0, 5) == 0) send_word(CODE_GOP);
    send_fillers($urandom_range(0, 4));
    if ($urandom_range(0, 7) != 0) send_word(CODE_AUDIO);
  endtask

  // A single stray word: random filler, a code on its own, a near-miss of a code, or an extreme value.
  task automatic send_noise();
    logic [31:0] codes[3];
    codes = '{CODE_GOP, CODE_VIDEO, CODE_AUDIO};
    case ($urandom_range(0, 4))
      0: send_word(filler_word());
      1: send_word(codes[$urandom_range(0, 2)] ^ (32'h1 << $urandom_range(0, 31)));
      2: send_word($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000);
      default: send_word(codes[$urandom_range(0, 2)]);
    endcase
  endtask

  // One random run with a fresh time step, set while the unit is idle.
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input logic [31:0] step);
    int unsigned goal;
    wait_for_records();
    write_reg(ADDR_TIME_STEP, step);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal = codes_sent + CODES_PER_RUN;
    while (codes_sent < goal) begin
      if ($urandom_range(0, 99) < 75) send_group();
      else send_noise();
    end
    wait_for_records();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_gop_at_start();
    test_code_handling();
    test_time_step();
    test_random_traffic(25, 85, $urandom());
    test_random_traffic(85, 25, 32'($urandom_range(0, 1000)));
    test_random_traffic(0, 0, $urandom());

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
